/* rtl/rcf_pkg.sv */
// Shared types, constants and helpers for the rendezvous channel FIFO.
// No dependencies; every rtl file but rcf_ram refers to it by scoped names.
package rcf_pkg;

  // Storage and field sizes
  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int TASK_BITS  = 8;
  localparam int CAP_W      = 5;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Word layouts
  localparam int S_FIELD_BITS = VALUE_BITS + TASK_BITS;
  localparam int S_TDATA_W    = ((S_FIELD_BITS + 7) / 8) * 8;
  localparam int M_FIELD_BITS = 1 + STATUS_W + VALUE_BITS + 1 + TASK_BITS + 1 + 1;
  localparam int M_TDATA_W    = ((M_FIELD_BITS + 7) / 8) * 8;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_TRY_SEND = 3'd0,
    KIND_TRY_RECV = 3'd1,
    KIND_SEND     = 3'd2,
    KIND_RECV     = 3'd3,
    KIND_CLOSE    = 3'd4
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_BLOCK  = 2'd1,
    STAT_CLOSED = 2'd2,
    STAT_PARKED = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic commit;   // apply the operation and load the result register
  } ctrl_cmd_t;

  // Ring index advance, wrapping at the live capacity
  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(idx) + CNT_W'(1);
    if (inc >= cap) begin
      next_index = '0;
    end else begin
      next_index = IDX_W'(inc);
    end
  endfunction

endpackage

/* rtl/rendezvous_channel_fifo.sv */
// Top level of the rendezvous channel FIFO: stream ports, controller and datapath.
// Depends on rcf_pkg, rcf_ctrl, rcf_datapath (and rcf_ram beneath it).
// Sequencing: an accepted word is captured, then executed, which raises m_tvalid;
//   execution waits while an earlier result is held and not being taken.
//   A new word is accepted only after the last one has executed against the
//   registered read of the slot store.
// Reset (rst, synchronous): capacity 16, channel empty and open, no task parked,
//   s_tready low. Slot store contents are not cleared and are only read once written.
module rendezvous_channel_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rcf_pkg::S_TDATA_W-1:0] s_tdata,   // send_value, task_id
  input  logic [rcf_pkg::KIND_W-1:0]    s_tuser,   // kind
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // ok, status, recv_value, woken_valid, woken_task, handoff, is_closed, zero pad
  output logic [rcf_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                          cfg_wr_en,
  input  logic [rcf_pkg::CAP_W-1:0]     cfg_wr_data
);

  rcf_pkg::ctrl_cmd_t cmd;

  // Sequencing
  rcf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd)
  );

  // Channel state and operation logic
  rcf_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .m_tdata    (m_tdata)
  );

endmodule

/* rtl/rcf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module rcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rcf_ctrl.sv */
// Controller for the rendezvous channel FIFO: accept/execute sequencing
// and output word valid. Depends on rcf_pkg.
module rcf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output rcf_pkg::ctrl_cmd_t cmd
);

  rcf_pkg::state_t state, state_next;
  logic            out_valid, out_valid_next;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rcf_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    s_tready    = 1'b0;
    unique case (state)
      rcf_pkg::ST_IDLE: begin
        // no word is taken while reset is held
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = rcf_pkg::ST_EXEC;
        end
      end
      rcf_pkg::ST_EXEC: begin
        // wait until the result register is free or draining
        if (!out_valid || m_tready) begin
          cmd.commit = 1'b1;
          state_next = rcf_pkg::ST_IDLE;
        end
      end
      default: state_next = rcf_pkg::ST_IDLE;
    endcase

    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

  // Checks
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("result not presented after commit");

  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == rcf_pkg::ST_EXEC))
    else $error("captured word not executed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !cmd.commit)
    else $error("pending result overwritten");

endmodule

/* rtl/rcf_datapath.sv */
// Datapath for the rendezvous channel FIFO: capacity register, ring state,
// parked slots, operation logic and result register. Depends on rcf_pkg, rcf_ram.
module rcf_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  rcf_pkg::ctrl_cmd_t            cmd,
  input  logic [rcf_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [rcf_pkg::KIND_W-1:0]    s_tuser,
  input  logic                          cfg_wr_en,
  input  logic [rcf_pkg::CAP_W-1:0]     cfg_wr_data,
  output logic [rcf_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int VB = rcf_pkg::VALUE_BITS;
  localparam int TB = rcf_pkg::TASK_BITS;
  localparam int IW = rcf_pkg::IDX_W;
  localparam int CW = rcf_pkg::CNT_W;

  // Captured operation
  rcf_pkg::kind_t op_kind;
  logic [VB-1:0]  op_value;
  logic [TB-1:0]  op_task;

  // Channel state
  logic [rcf_pkg::CAP_W-1:0] capacity;
  logic [IW-1:0] read_index, read_index_next;
  logic [IW-1:0] write_index, write_index_next;
  logic [CW-1:0] fill_count, fill_count_next;
  logic          closed_flag, closed_flag_next;
  logic          sender_parked, sender_parked_next;
  logic [TB-1:0] tx_wait_task, tx_wait_task_next;
  logic [VB-1:0] pending_value, pending_value_next;
  logic          receiver_parked, receiver_parked_next;
  logic [TB-1:0] rx_wait_task, rx_wait_task_next;

  // Result register
  logic                res_ok, ok_next;
  rcf_pkg::status_t    res_status, status_next;
  logic [VB-1:0]       res_recv, recv_next;
  logic                res_wv, wv_next;
  logic [TB-1:0]       res_wt, wt_next;
  logic                res_handoff, handoff_next;
  logic                res_closed;

  // Slot store port signals
  logic          ram_we;
  logic [VB-1:0] ram_wdata;
  logic [VB-1:0] ram_rdata;

  logic [CW-1:0] cap;
  logic          cap_zero;
  logic          full;
  logic          can_pop;
  logic          send_blocked;

  // Slot store; read port always addresses the head slot
  rcf_ram #(
    .WIDTH(VB),
    .DEPTH(rcf_pkg::DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(write_index),
    .wdata(ram_wdata),
    .raddr(read_index),
    .rdata(ram_rdata)
  );

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= rcf_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Live capacity, clamped to the store depth
  assign cap = (32'(capacity) > 32'(rcf_pkg::DEPTH)) ? CW'(rcf_pkg::DEPTH) : CW'(capacity);
  assign cap_zero = (cap == '0);
  assign full     = (fill_count >= cap);
  assign can_pop  = !cap_zero && (fill_count != '0);

  // Capture incoming word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind  <= rcf_pkg::kind_t'(s_tuser);
      op_value <= s_tdata[VB-1:0];
      op_task  <= s_tdata[VB+TB-1:VB];
    end
  end

  // Operation logic
  always_comb begin
    read_index_next      = read_index;
    write_index_next     = write_index;
    fill_count_next      = fill_count;
    closed_flag_next     = closed_flag;
    sender_parked_next   = sender_parked;
    tx_wait_task_next    = tx_wait_task;
    pending_value_next   = pending_value;
    receiver_parked_next = receiver_parked;
    rx_wait_task_next    = rx_wait_task;
    ok_next      = 1'b0;
    status_next  = rcf_pkg::STAT_DONE;
    recv_next    = '0;
    wv_next      = 1'b0;
    wt_next      = '0;
    handoff_next = 1'b0;
    ram_we       = 1'b0;
    ram_wdata    = op_value;
    send_blocked = 1'b0;

    unique case (op_kind) inside
      rcf_pkg::KIND_TRY_SEND, rcf_pkg::KIND_SEND: begin
        if (closed_flag) begin
          status_next = rcf_pkg::STAT_CLOSED;
        end else if (cap_zero) begin
          // unbuffered: hand straight to a parked receiver
          if (receiver_parked) begin
            recv_next            = op_value;
            pending_value_next   = op_value;
            receiver_parked_next = 1'b0;
            wv_next              = 1'b1;
            wt_next              = rx_wait_task;
            handoff_next         = 1'b1;
            ok_next              = 1'b1;
          end else begin
            send_blocked = 1'b1;
          end
        end else if (full) begin
          send_blocked = 1'b1;
        end else begin
          ram_we           = 1'b1;
          write_index_next = rcf_pkg::next_index(write_index, cap);
          fill_count_next  = fill_count + CW'(1);
          if (receiver_parked) begin
            receiver_parked_next = 1'b0;
            wv_next              = 1'b1;
            wt_next              = rx_wait_task;
          end
          ok_next = 1'b1;
        end
        // blocking send parks instead of reporting would-block
        if (send_blocked) begin
          if (op_kind == rcf_pkg::KIND_SEND) begin
            tx_wait_task_next  = op_task;
            pending_value_next = op_value;
            sender_parked_next = 1'b1;
            ok_next            = 1'b1;
            status_next        = rcf_pkg::STAT_PARKED;
          end else begin
            status_next = rcf_pkg::STAT_BLOCK;
          end
        end
      end
      rcf_pkg::KIND_TRY_RECV, rcf_pkg::KIND_RECV: begin
        if (can_pop) begin
          recv_next       = ram_rdata;
          read_index_next = rcf_pkg::next_index(read_index, cap);
          fill_count_next = fill_count - CW'(1);
          if (sender_parked) begin
            // refill the freed slot; value dropped if still no room
            if (fill_count <= cap) begin
              ram_we           = 1'b1;
              ram_wdata        = pending_value;
              write_index_next = rcf_pkg::next_index(write_index, cap);
              fill_count_next  = fill_count;
            end
            sender_parked_next = 1'b0;
            wv_next            = 1'b1;
            wt_next            = tx_wait_task;
          end
          ok_next = 1'b1;
        end else if (sender_parked) begin
          recv_next          = pending_value;
          sender_parked_next = 1'b0;
          wv_next            = 1'b1;
          wt_next            = tx_wait_task;
          ok_next            = 1'b1;
        end else if (closed_flag) begin
          status_next = rcf_pkg::STAT_CLOSED;
        end else if (op_kind == rcf_pkg::KIND_RECV) begin
          rx_wait_task_next    = op_task;
          receiver_parked_next = 1'b1;
          ok_next              = 1'b1;
          status_next          = rcf_pkg::STAT_PARKED;
        end else begin
          status_next = rcf_pkg::STAT_BLOCK;
        end
      end
      rcf_pkg::KIND_CLOSE: begin
        closed_flag_next = 1'b1;
        ok_next          = 1'b1;
      end
      default: begin
        // unknown kind: no effect
      end
    endcase

    if (!cmd.commit) begin
      ram_we = 1'b0;
    end
  end

  // Channel state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_index      <= '0;
      write_index     <= '0;
      fill_count      <= '0;
      closed_flag     <= 1'b0;
      sender_parked   <= 1'b0;
      tx_wait_task    <= '0;
      pending_value   <= '0;
      receiver_parked <= 1'b0;
      rx_wait_task    <= '0;
    end else if (cmd.commit) begin
      read_index      <= read_index_next;
      write_index     <= write_index_next;
      fill_count      <= fill_count_next;
      closed_flag     <= closed_flag_next;
      sender_parked   <= sender_parked_next;
      tx_wait_task    <= tx_wait_task_next;
      pending_value   <= pending_value_next;
      receiver_parked <= receiver_parked_next;
      rx_wait_task    <= rx_wait_task_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_ok      <= ok_next;
      res_status  <= status_next;
      res_recv    <= recv_next;
      res_wv      <= wv_next;
      res_wt      <= wt_next;
      res_handoff <= handoff_next;
      res_closed  <= closed_flag_next;
    end
  end

  assign m_tdata = rcf_pkg::M_TDATA_W'({res_closed, res_handoff, res_wt, res_wv,
                                        res_recv, res_status, res_ok});

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(rcf_pkg::DEPTH))
    else $error("fill count beyond store depth");

  a_write_on_commit: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> cmd.commit)
    else $error("slot write outside commit");

  a_handoff_wakes: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && handoff_next |=> res_wv && res_ok)
    else $error("handoff without woken receiver");

endmodule

/* dv/tb_rendezvous_channel_fifo.sv */
// Self-checking testbench for the rendezvous channel FIFO: directed operations, then random phases.
// Depends on rcf_pkg and the rtl top level; predicts every result word and checks it field by field.
`timescale 1ns / 100ps

module tb_rendezvous_channel_fifo;
  import rcf_pkg::*;

  // One channel operation as it travels on the slave side
  typedef struct {
    kind_t                 kind;
    logic [VALUE_BITS-1:0] send_value;
    logic [TASK_BITS-1:0]  task_id;
  } chan_op_t;

  // Result word, MSB first so that it lines up with m_tdata
  typedef struct packed {
    logic                  is_closed;
    logic                  handoff;
    logic [TASK_BITS-1:0]  woken_task;
    logic                  woken_valid;
    logic [VALUE_BITS-1:0] recv_value;
    status_t               status;
    logic                  ok;
  } chan_result_t;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   s_tvalid    = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata     = '0;
  logic [KIND_W-1:0]      s_tuser     = '0;
  logic                   m_tvalid;
  logic                   m_tready    = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0]       cfg_wr_data = '0;

  chan_op_t     pending_ops[$];
  chan_result_t expected_results[$];
  chan_op_t     cur_op;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           mismatch_count = 0;

  // Channel state as the block should hold it
  logic [VALUE_BITS-1:0] slot_model[DEPTH];
  logic [DEPTH-1:0]      slot_written = '0;
  logic [IDX_W-1:0]      rd_ptr       = '0;
  logic [IDX_W-1:0]      wr_ptr       = '0;
  int                    fill_cnt     = 0;
  int                    cap_reg      = 16;
  bit                    chan_closed  = 1'b0;
  bit                    snd_parked   = 1'b0;
  logic [TASK_BITS-1:0]  snd_task     = '0;
  logic [VALUE_BITS-1:0] parked_value = '0;
  bit                    rcv_parked   = 1'b0;
  logic [TASK_BITS-1:0]  rcv_task     = '0;

  rendezvous_channel_fifo i_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Capacity register values above DEPTH behave as DEPTH
  function automatic int live_cap();
    return (cap_reg > DEPTH) ? DEPTH : cap_reg;
  endfunction

  function automatic logic [IDX_W-1:0] ring_advance(input logic [IDX_W-1:0] idx, input int cap);
    int n;
    n = int'(idx) + 1;
    return (n >= cap) ? '0 : IDX_W'(n);
  endfunction

  function automatic void push_slot(input logic [VALUE_BITS-1:0] v);
    int cap;
    cap = live_cap();
    if (cap == 0 || fill_cnt >= cap) return;
    slot_model[wr_ptr]   = v;
    slot_written[wr_ptr] = 1'b1;
    wr_ptr               = ring_advance(wr_ptr, cap);
    fill_cnt++;
  endfunction

  function automatic logic [VALUE_BITS-1:0] pop_slot();
    logic [VALUE_BITS-1:0] v;
    v        = slot_model[rd_ptr];
    rd_ptr   = ring_advance(rd_ptr, live_cap());
    fill_cnt--;
    return v;
  endfunction

  // Non-blocking send: rendezvous at capacity 0, otherwise into the ring
  function automatic void offer_value(input logic [VALUE_BITS-1:0] v, inout chan_result_t r);
    int cap;
    cap = live_cap();
    if (chan_closed) begin
      r.status = STAT_CLOSED;
      return;
    end
    if (cap == 0) begin
      if (!rcv_parked) begin
        r.status = STAT_BLOCK;
        return;
      end
      r.recv_value  = v;
      parked_value  = v;
      rcv_parked    = 1'b0;
      r.woken_valid = 1'b1;
      r.woken_task  = rcv_task;
      r.handoff     = 1'b1;
      r.ok          = 1'b1;
      return;
    end
    if (fill_cnt >= cap) begin
      r.status = STAT_BLOCK;
      return;
    end
    push_slot(v);
    // a parked receiver is woken but gets no value
    if (rcv_parked) begin
      rcv_parked    = 1'b0;
      r.woken_valid = 1'b1;
      r.woken_task  = rcv_task;
    end
    r.ok = 1'b1;
  endfunction

  // Non-blocking receive: ring first, then a parked sender's value
  function automatic void take_value(inout chan_result_t r);
    if (live_cap() > 0 && fill_cnt > 0) begin
      r.recv_value = pop_slot();
      // parked sender refills the freed slot (dropped if none is free)
      if (snd_parked) begin
        push_slot(parked_value);
        snd_parked    = 1'b0;
        r.woken_valid = 1'b1;
        r.woken_task  = snd_task;
      end
      r.ok = 1'b1;
      return;
    end
    if (snd_parked) begin
      r.recv_value  = parked_value;
      snd_parked    = 1'b0;
      r.woken_valid = 1'b1;
      r.woken_task  = snd_task;
      r.ok          = 1'b1;
      return;
    end
    r.status = chan_closed ? STAT_CLOSED : STAT_BLOCK;
  endfunction

  function automatic chan_result_t predict_channel_op(input chan_op_t op);
    chan_result_t r;
    r = '0;
    case (op.kind)
      KIND_TRY_SEND: offer_value(op.send_value, r);
      KIND_TRY_RECV: take_value(r);
      KIND_SEND: begin
        if (chan_closed) begin
          r.status = STAT_CLOSED;
        end else begin
          offer_value(op.send_value, r);
          // park, replacing any sender already parked
          if (!r.ok) begin
            snd_task     = op.task_id;
            parked_value = op.send_value;
            snd_parked   = 1'b1;
            r.ok         = 1'b1;
            r.status     = STAT_PARKED;
          end
        end
      end
      KIND_RECV: begin
        take_value(r);
        if (!r.ok) begin
          if (chan_closed) begin
            r.status     = STAT_CLOSED;
            r.recv_value = '0;
          end else begin
            rcv_task   = op.task_id;
            rcv_parked = 1'b1;
            r.ok       = 1'b1;
            r.status   = STAT_PARKED;
          end
        end
      end
      KIND_CLOSE: begin
        chan_closed = 1'b1;
        r.ok        = 1'b1;
        r.status    = STAT_DONE;
      end
      default: ;
    endcase
    r.is_closed = chan_closed;
    return r;
  endfunction

  // Slave side: predict on acceptance, then offer the next pending word
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(predict_channel_op(cur_op));
      if (!s_tvalid || s_tready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_op   = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= S_TDATA_W'({cur_op.task_id, cur_op.send_value});
          s_tuser  <= cur_op.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void note_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    end
  endfunction

  // Master side: check each result word against the oldest expectation
  always @(posedge clk) begin : result_check
    chan_result_t got;
    chan_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = chan_result_t'(m_tdata[M_FIELD_BITS-1:0]);
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("%0t: unexpected result word %h", $realtime, got);
        end else begin
          want = expected_results.pop_front();
          note_mismatch("ok", want.ok, got.ok);
          note_mismatch("status", want.status, got.status);
          note_mismatch("recv_value", want.recv_value, got.recv_value);
          note_mismatch("woken_valid", want.woken_valid, got.woken_valid);
          note_mismatch("woken_task", want.woken_task, got.woken_task);
          note_mismatch("handoff", want.handoff, got.handoff);
          note_mismatch("is_closed", want.is_closed, got.is_closed);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_op(input kind_t kind, input logic [VALUE_BITS-1:0] v,
                          input logic [TASK_BITS-1:0] t);
    chan_op_t op;
    op.kind       = kind;
    op.send_value = v;
    op.task_id    = t;
    pending_ops.push_back(op);
  endtask

  // Waits until every word is sent and every result is back
  task automatic wait_drained();
    while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input int cap);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CAP_W'(cap);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cap_reg     = cap;
  endtask

  task automatic queue_random_ops(input int n, input int send_pct, input bit with_close);
    logic [VALUE_BITS-1:0] v;
    int                    pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(15);
      v    = (pick == 0) ? '0 : (pick == 1) ? '1 : VALUE_BITS'($urandom);
      if (with_close && (i == n / 3 || $urandom_range(99) < 2)) begin
        queue_op(KIND_CLOSE, v, TASK_BITS'($urandom_range(255)));
      end else if ($urandom_range(99) < send_pct) begin
        queue_op($urandom_range(1) ? KIND_SEND : KIND_TRY_SEND, v,
                 TASK_BITS'($urandom_range(255)));
      end else begin
        queue_op($urandom_range(1) ? KIND_RECV : KIND_TRY_RECV, v,
                 TASK_BITS'($urandom_range(255)));
      end
    end
  endtask

  // Stimulus
  initial begin : stimulus
    int caps[10]     = '{16, 0, 1, 2, 16, 4, 0, 15, 1, 16};
    int send_mix[10] = '{70, 50, 45, 55, 40, 60, 50, 65, 50, 50};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // buffered: empty receive, receivers parking and being replaced, wake without value
    write_capacity(16);
    queue_op(KIND_TRY_RECV, '0, '0);
    queue_op(KIND_RECV, '0, 8'hFF);
    queue_op(KIND_RECV, '0, 8'h00);
    queue_op(KIND_TRY_SEND, 32'hFFFF_FFFF, 8'h11);
    queue_op(KIND_TRY_SEND, 32'h0000_0000, 8'h22);
    queue_op(KIND_TRY_RECV, '0, '0);
    queue_op(KIND_RECV, '0, 8'h44);
    queue_op(KIND_SEND, 32'hDEAD_BEEF, 8'hAA);
    queue_op(KIND_TRY_RECV, '0, '0);

    // unbuffered rendezvous: parked sender replaced, handoff to parked receiver
    write_capacity(0);
    queue_op(KIND_TRY_SEND, 32'h0BAD_F00D, 8'h01);
    queue_op(KIND_TRY_RECV, '0, '0);
    queue_op(KIND_SEND, 32'h5A5A_5A5A, 8'h01);
    queue_op(KIND_SEND, 32'hA5A5_A5A5, 8'h80);
    queue_op(KIND_TRY_RECV, '0, '0);
    queue_op(KIND_RECV, '0, 8'h7F);
    queue_op(KIND_TRY_SEND, 32'h1234_5678, 8'h02);
    queue_op(KIND_RECV, '0, 8'h55);
    queue_op(KIND_SEND, 32'h8000_0001, 8'h33);

    // single slot: full buffer parks the sender, a pop pulls its value in
    write_capacity(1);
    queue_op(KIND_TRY_SEND, 32'h0000_0001, 8'h10);
    queue_op(KIND_SEND, 32'h7FFF_FFFE, 8'hC3);
    queue_op(KIND_TRY_RECV, '0, '0);
    queue_op(KIND_TRY_RECV, '0, '0);

    // random phases; the last one closes the channel partway through
    for (int p = 0; p < 10; p++) begin
      wait_drained();
      // capacity may only move with values held once every slot has been written
      while (fill_cnt != 0 && !(&slot_written)) begin
        queue_op(KIND_TRY_RECV, '0, '0);
        wait_drained();
      end
      write_capacity(caps[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      queue_random_ops(93, send_mix[p], p == 9);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
